// ===== design/priority_timeslice_job_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_TIMESLICE_JOB_SCHEDULER_DEFINES_SVH
`define PRIORITY_TIMESLICE_JOB_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property, sampled on the rising clock edge, off during reset.
`define PTJS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("scheduler assertion failed");
// Condition must hold in the cycle after the trigger.
`define PTJS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define PTJS_ASSERT(label, clk, rstn, prop)
`define PTJS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== design/ptjs_pkg.sv =====
// Types and constants of the priority time-slice job scheduler.
package ptjs_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int JOB_W           = 6;
    localparam int ARR_W           = 16;
    localparam int PRIO_W          = 10;
    localparam int RUN_W           = 16;
    localparam int TIME_W          = 32;
    localparam int SLICE_W         = 8;

    localparam logic [PRIO_W-1:0]  PRIO_SENTINEL = PRIO_W'(1000);
    localparam logic [SLICE_W-1:0] SLICE_RESET   = SLICE_W'(1);

    // func codes
    localparam logic FUNC_APPEND   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ARR_W-1:0]  job_arrival;
        logic [PRIO_W-1:0] job_priority;
        logic [RUN_W-1:0]  job_run_time;
    } in_item_t;

    typedef struct packed {
        logic [JOB_W-1:0]  chosen_job;
        logic              first_start;
        logic              job_done;
        logic              all_done;
        logic              table_full;
        logic [TIME_W-1:0] time_now;
    } out_item_t;

    // One job table entry as held in the RAM.
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [PRIO_W-1:0] priority_num;
        logic [RUN_W-1:0]  remaining;
        logic              started;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic do_append;
        logic do_commit;
    } ptjs_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic in_func;
        logic count_zero;
        logic scan_last;
        logic out_free;
    } ptjs_status_t;

endpackage

// ===== design/priority_timeslice_job_scheduler.sv =====
// Top level of the priority time-slice job scheduler.
//
//  channel   ports                        payload
//  input     s_valid / s_ready / s_data   in_item_t: func, arrival, priority, run time
//  result    m_valid / m_ready / m_data   out_item_t: job, flags, time_now
//  config    cfg_we / cfg_wdata           slice_length, 8 bits
//
// An append waits only for a free output register. A dispatch with an empty
// table goes straight to commit; otherwise the table RAM is read one entry per
// cycle, each entry is compared against the running best, then a commit writes back.
// Reset is synchronous and clears the job count, clock and last-job state;
// the table needs no clearing. A result held in the output register does not
// block acceptance; a new result waits only while that register is still full.
`include "priority_timeslice_job_scheduler_defines.svh"

module priority_timeslice_job_scheduler #(
    parameter int MAX_ENTRIES = ptjs_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ptjs_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ptjs_pkg::out_item_t           m_data,
    input  logic                         cfg_we,
    input  logic [ptjs_pkg::SLICE_W-1:0] cfg_wdata
);

    ptjs_pkg::ptjs_cmd_t    cmd;
    ptjs_pkg::ptjs_status_t status;

    ptjs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ptjs_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a transaction moves the controller out of idle
    `PTJS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // results are only written into a free output register
    `PTJS_ASSERT(a_commit_free, aclk, aresetn, !(cmd.do_commit || cmd.do_append) || status.out_free)
    // an empty dispatch carries no job information
    `PTJS_ASSERT(a_all_done_clean, aclk, aresetn, !(m_valid && m_data.all_done) || (!m_data.first_start && !m_data.job_done && !m_data.table_full && m_data.chosen_job == '0))

endmodule

// ===== design/ptjs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ptjs_ctrl.sv =====
// Controller state machine: accept, append, table scan and commit sequencing.
module ptjs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ptjs_pkg::ptjs_status_t status,
    output ptjs_pkg::ptjs_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_APPEND = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.in_func == ptjs_pkg::FUNC_APPEND) begin
                        state_next = ST_APPEND;
                    end else if (status.count_zero) begin
                        state_next = ST_COMMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_APPEND: begin
                if (status.out_free) begin
                    cmd.do_append = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read comes back and is compared here
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.do_commit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ptjs_dpath.sv =====
// Datapath: job table, scan comparator, scheduler state and output register.
module ptjs_dpath #(
    parameter int MAX_ENTRIES = ptjs_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ptjs_pkg::ptjs_cmd_t                 cmd,
    output ptjs_pkg::ptjs_status_t              status,
    input  ptjs_pkg::in_item_t                  s_data,
    input  logic                               cfg_we,
    input  logic [ptjs_pkg::SLICE_W-1:0]       cfg_wdata,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ptjs_pkg::out_item_t                 m_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = $bits(ptjs_pkg::entry_t);

    // scheduler state
    ptjs_pkg::in_item_t                item_reg;
    logic [CNT_W-1:0]                 job_count_reg;
    logic [ptjs_pkg::TIME_W-1:0]      clock_reg;
    logic [IDX_W-1:0]                 last_job_reg;
    logic                             last_valid_reg;
    logic [ptjs_pkg::SLICE_W-1:0]     slice_reg;

    // scan state
    logic [IDX_W-1:0]                 rd_idx_reg;
    logic                             cmp_vld_reg;
    logic [IDX_W-1:0]                 cmp_idx_reg;
    logic                             any_elig_reg;
    logic                             have_best_reg;
    logic [IDX_W-1:0]                 best_idx_reg;
    ptjs_pkg::entry_t                  best_ent_reg;
    logic                             last_found_reg;
    ptjs_pkg::entry_t                  last_ent_reg;

    // output register
    logic                             m_valid_reg;
    ptjs_pkg::out_item_t               m_data_reg;
    ptjs_pkg::out_item_t               m_data_next;

    // RAM ports
    logic                             ram_we;
    logic [IDX_W-1:0]                 ram_waddr;
    ptjs_pkg::entry_t                  ram_wdata;
    ptjs_pkg::entry_t                  rd_ent;
    logic [ENT_W-1:0]                 rd_raw;

    logic                             out_free;
    logic                             table_full;
    logic                             elig;
    logic                             is_last;
    logic                             cand;
    logic                             better;
    logic                             nothing;
    logic [IDX_W-1:0]                 sel_idx;
    ptjs_pkg::entry_t                  sel_ent;
    logic [ptjs_pkg::RUN_W-1:0]       slice_ext;
    logic [ptjs_pkg::RUN_W-1:0]       new_rem;
    logic [ptjs_pkg::TIME_W-1:0]      clock_next;

    ptjs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.scan_issue),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_raw)
    );

    assign rd_ent = ptjs_pkg::entry_t'(rd_raw);

    // status back to the controller
    assign out_free          = !m_valid_reg || m_ready;
    assign status.in_func    = s_data.func;
    assign status.count_zero = (job_count_reg == '0);
    assign status.scan_last  = (rd_idx_reg == IDX_W'(job_count_reg - CNT_W'(1)));
    assign status.out_free   = out_free;

    assign table_full = (job_count_reg >= CNT_W'(MAX_ENTRIES));

    // per-entry compare against the running best
    always_comb begin
        elig    = (rd_ent.remaining != '0) &&
                  (ptjs_pkg::TIME_W'(rd_ent.arrival) <= clock_reg);
        is_last = last_valid_reg && (cmp_idx_reg == last_job_reg);
        cand    = elig && !is_last && (rd_ent.priority_num < ptjs_pkg::PRIO_SENTINEL);
        better  = !have_best_reg ||
                  (rd_ent.priority_num < best_ent_reg.priority_num) ||
                  ((rd_ent.priority_num == best_ent_reg.priority_num) &&
                   ((rd_ent.arrival < best_ent_reg.arrival) ||
                    ((rd_ent.arrival == best_ent_reg.arrival) &&
                     (rd_ent.remaining < best_ent_reg.remaining))));
    end

    // slice selection and update of the chosen job
    always_comb begin
        sel_idx    = have_best_reg ? best_idx_reg : last_job_reg;
        sel_ent    = have_best_reg ? best_ent_reg : last_ent_reg;
        nothing    = !have_best_reg && (!any_elig_reg || !last_valid_reg || !last_found_reg);
        slice_ext  = ptjs_pkg::RUN_W'(slice_reg);
        new_rem    = (sel_ent.remaining > slice_ext) ? sel_ent.remaining - slice_ext : '0;
        clock_next = clock_reg + ptjs_pkg::TIME_W'(slice_reg);
    end

    // table writes: append a fresh entry or write back the dispatched one
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sel_idx;
        ram_wdata = sel_ent;
        if (cmd.do_append) begin
            ram_we                 = !table_full;
            ram_waddr              = IDX_W'(job_count_reg);
            ram_wdata.arrival      = item_reg.job_arrival;
            ram_wdata.priority_num = item_reg.job_priority;
            ram_wdata.remaining    = item_reg.job_run_time;
            ram_wdata.started      = 1'b0;
        end else if (cmd.do_commit) begin
            ram_we            = !nothing;
            ram_wdata.remaining = new_rem;
            ram_wdata.started = 1'b1;
        end
    end

    // result of the current append or dispatch
    always_comb begin
        m_data_next = '0;
        if (cmd.do_append) begin
            m_data_next.chosen_job = table_full ? '0 : ptjs_pkg::JOB_W'(job_count_reg);
            m_data_next.table_full = table_full;
            m_data_next.time_now   = clock_reg;
        end else if (nothing) begin
            m_data_next.all_done = 1'b1;
            m_data_next.time_now = clock_reg;
        end else begin
            m_data_next.chosen_job  = ptjs_pkg::JOB_W'(sel_idx);
            m_data_next.first_start = !sel_ent.started;
            m_data_next.job_done    = (new_rem == '0);
            m_data_next.time_now    = clock_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_count_reg  <= '0;
            clock_reg      <= '0;
            last_job_reg   <= '0;
            last_valid_reg <= 1'b0;
            slice_reg      <= ptjs_pkg::SLICE_RESET;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            any_elig_reg   <= 1'b0;
            have_best_reg  <= 1'b0;
            last_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                slice_reg <= cfg_wdata;
            end
            cmp_vld_reg <= cmd.scan_issue;
            if (cmd.accept) begin
                rd_idx_reg     <= '0;
                any_elig_reg   <= 1'b0;
                have_best_reg  <= 1'b0;
                last_found_reg <= 1'b0;
            end
            if (cmd.scan_issue) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (cmp_vld_reg) begin
                if (elig) begin
                    any_elig_reg <= 1'b1;
                end
                if (cand && better) begin
                    have_best_reg <= 1'b1;
                end
                if (cmp_idx_reg == last_job_reg) begin
                    last_found_reg <= 1'b1;
                end
            end
            if (cmd.do_append && !table_full) begin
                job_count_reg <= job_count_reg + CNT_W'(1);
            end
            if (cmd.do_commit && !nothing) begin
                clock_reg      <= clock_next;
                last_job_reg   <= sel_idx;
                last_valid_reg <= 1'b1;
            end
            if (cmd.do_append || cmd.do_commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.scan_issue) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmp_vld_reg) begin
            if (cand && better) begin
                best_idx_reg <= cmp_idx_reg;
                best_ent_reg <= rd_ent;
            end
            if (cmp_idx_reg == last_job_reg) begin
                last_ent_reg <= rd_ent;
            end
        end
        if (cmd.do_append || cmd.do_commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
